// ===== sv/pscc_pkg.sv =====
// pscc_pkg: shared types and constants for the point set coplanarity check.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pscc_pkg;

	// Depth of the queues in front of and behind the evaluator.
	localparam int QUEUE_DEPTH = 2;

	// Evaluator sequencer states.
	typedef enum logic [4:0] {
		S_TAKE  = 5'b00001,
		S_SUM   = 5'b00010,
		S_CROSS = 5'b00100,
		S_OMUL  = 5'b01000,
		S_OSUM  = 5'b10000
	} state_t;

	// Queue status as seen by the neighbor.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// One result beat.
	typedef struct packed {
		logic coplanar;
		logic all_collinear;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/pscc_fifo.sv =====
// pscc_fifo: small register queue used for incoming points and for results.
// Depends on pscc_pkg (qstat_t).
`default_nettype none

module pscc_fifo import pscc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output qstat_t           stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== sv/pscc_back.sv =====
// pscc_back: evaluator that classifies each queued point and runs the
// direction, cross product and plane checks. Depends on pscc_pkg.
`default_nettype none

module pscc_back import pscc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] q_x,
	input  logic [COORD_BITS-1:0] q_y,
	input  logic [COORD_BITS-1:0] q_z,
	input  logic                  q_last,
	input  qstat_t                in_stat,
	output logic                  in_pop,
	input  qstat_t                res_stat,
	output logic                  res_push,
	output res_t                  res_data
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;       // difference
	localparam int XW = 2 * CW + 2;   // cross partial product
	localparam int NW = 2 * CW + 3;   // normal component
	localparam int PW = 3 * CW + 3;   // dot partial product
	localparam int OW = 3 * CW + 5;   // dot sum / offset

	state_t state_q, state_d;

	logic signed [CW-1:0] org_q [3];
	logic signed [DW-1:0] dir_q [3];
	logic signed [NW-1:0] nrm_q [3];
	logic signed [OW-1:0] ofs_q;
	logic signed [XW-1:0] xp_q  [6];
	logic signed [PW-1:0] dp_q  [3];

	logic seen_q, have_dir_q, have_nrm_q, still_q, last_q;

	logic signed [CW-1:0] pt    [3];
	logic signed [DW-1:0] dif   [3];
	logic signed [XW-1:0] xp_d  [6];
	logic signed [CW-1:0] mul_a [3];
	logic signed [PW-1:0] dp_d  [3];
	logic signed [NW-1:0] crs   [3];
	logic signed [OW-1:0] dot;

	logic take, dif_nz, crs_nz, fin, fin_last, still_d, hn_d, set_dir;

	assign pt[0] = $signed(q_x);
	assign pt[1] = $signed(q_y);
	assign pt[2] = $signed(q_z);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i]   = DW'(pt[i]) - DW'(org_q[i]);
			mul_a[i] = (state_q == S_OMUL) ? org_q[i] : pt[i];
			dp_d[i]  = PW'(mul_a[i]) * PW'(nrm_q[i]);
		end
		// cross partial products, base direction x new difference
		xp_d[0] = XW'(dir_q[1]) * XW'(dif[2]);
		xp_d[1] = XW'(dir_q[2]) * XW'(dif[1]);
		xp_d[2] = XW'(dir_q[2]) * XW'(dif[0]);
		xp_d[3] = XW'(dir_q[0]) * XW'(dif[2]);
		xp_d[4] = XW'(dir_q[0]) * XW'(dif[1]);
		xp_d[5] = XW'(dir_q[1]) * XW'(dif[0]);
		crs[0]  = NW'(xp_q[0]) - NW'(xp_q[1]);
		crs[1]  = NW'(xp_q[2]) - NW'(xp_q[3]);
		crs[2]  = NW'(xp_q[4]) - NW'(xp_q[5]);
		dot     = OW'(dp_q[0]) + OW'(dp_q[1]) + OW'(dp_q[2]);
	end

	assign dif_nz = (dif[0] != '0) || (dif[1] != '0) || (dif[2] != '0);
	assign crs_nz = (crs[0] != '0) || (crs[1] != '0) || (crs[2] != '0);

	// one item in flight; start only when its result has room
	assign take    = (state_q == S_TAKE) && !in_stat.empty && !res_stat.full;
	assign in_pop  = take;
	assign set_dir = take && seen_q && !have_nrm_q && !have_dir_q && dif_nz;

	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		still_d = still_q;
		hn_d    = have_nrm_q;
		unique case (state_q)
			S_TAKE: begin
				if (take) begin
					if (!seen_q || (!have_nrm_q && !have_dir_q)) begin
						fin = 1'b1;
					end else if (have_nrm_q) begin
						state_d = S_SUM;
					end else begin
						state_d = S_CROSS;
					end
				end
			end
			S_SUM: begin
				if (dot != ofs_q) begin
					still_d = 1'b0;
				end
				fin     = 1'b1;
				state_d = S_TAKE;
			end
			S_CROSS: begin
				if (crs_nz) begin
					hn_d    = 1'b1;
					state_d = S_OMUL;
				end else begin
					fin     = 1'b1;
					state_d = S_TAKE;
				end
			end
			S_OMUL: begin
				state_d = S_OSUM;
			end
			S_OSUM: begin
				fin     = 1'b1;
				state_d = S_TAKE;
			end
			default: begin
				state_d = S_TAKE;
			end
		endcase
	end

	assign fin_last               = fin && (take ? q_last : last_q);
	assign res_push               = fin_last;
	assign res_data.coplanar      = still_d;
	assign res_data.all_collinear = !hn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_TAKE;
			seen_q     <= 1'b0;
			have_dir_q <= 1'b0;
			have_nrm_q <= 1'b0;
			still_q    <= 1'b1;
			last_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				last_q <= q_last;
			end
			if (fin_last) begin
				// end of set: back to a fresh set
				seen_q     <= 1'b0;
				have_dir_q <= 1'b0;
				have_nrm_q <= 1'b0;
				still_q    <= 1'b1;
			end else begin
				still_q    <= still_d;
				have_nrm_q <= hn_d;
				if (take) begin
					seen_q <= 1'b1;
				end
				if (set_dir) begin
					have_dir_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !seen_q) begin
			org_q <= pt;
		end
		if (set_dir) begin
			dir_q <= dif;
		end
		if (take) begin
			xp_q <= xp_d;
		end
		if (take || state_q == S_OMUL) begin
			dp_q <= dp_d;
		end
		if (state_q == S_CROSS) begin
			nrm_q <= crs;
		end
		if (state_q == S_OSUM) begin
			ofs_q <= dot;
		end
	end

endmodule

`default_nettype wire

// ===== sv/point_set_coplanarity_check.sv =====
// point_set_coplanarity_check: top level; input point queue, evaluator and
// result queue. Depends on pscc_pkg, pscc_fifo and pscc_back.
`default_nettype none

// Streams signed 3D points, one set at a time, and reports on the point marked
// last whether the whole set lies in one plane (coplanar) and whether no plane
// normal could be formed at all (all_collinear: every point on one line or
// coincident). The first point is the origin, the first point that differs
// from it fixes the base direction, the first point whose difference crosses
// to a nonzero normal fixes the plane, and every point after that is checked
// by dot product against the plane offset. Both sides are queues: points go in
// with push while full is low, a result waits while empty is low and leaves
// with pop. A two-beat queue sits on each side, so points are taken while a
// result waits. The evaluator ends the origin and direction-seeking points in
// the take state; a point checked against the plane goes through the three
// shared dot-product multipliers, then the sum and compare; a cross product
// that stays zero ends after the cross step; the point that finds the normal
// runs the cross product, then the origin dot product on the same multipliers.
// The evaluator starts a point only when the result queue has room. A set ends
// at its last point; all set state clears there for the next set.

module point_set_coplanarity_check import pscc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	input  logic [COORD_BITS-1:0] coord_z,
	input  logic                  last_point,
	output logic                  empty,
	input  logic                  pop,
	output logic                  coplanar,
	output logic                  all_collinear
);

	localparam int PT_W = 3 * COORD_BITS + 1;

	qstat_t                in_stat;
	qstat_t                res_stat;
	logic [PT_W-1:0]       pt_word;
	logic                  in_pop;
	logic                  res_push;
	res_t                  res_in;
	logic [$bits(res_t)-1:0] res_word;
	res_t                  res_out;

	// point queue
	pscc_fifo #(
		.WIDTH (PT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({last_point, coord_z, coord_y, coord_x}),
		.pop    (in_pop),
		.rdata  (pt_word),
		.stat   (in_stat)
	);

	pscc_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_x      (pt_word[COORD_BITS-1:0]),
		.q_y      (pt_word[2*COORD_BITS-1:COORD_BITS]),
		.q_z      (pt_word[3*COORD_BITS-1:2*COORD_BITS]),
		.q_last   (pt_word[PT_W-1]),
		.in_stat  (in_stat),
		.in_pop   (in_pop),
		.res_stat (res_stat),
		.res_push (res_push),
		.res_data (res_in)
	);

	// result queue
	pscc_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_word),
		.stat   (res_stat)
	);

	assign res_out       = res_t'(res_word);
	assign full          = in_stat.full;
	assign empty         = res_stat.empty;
	assign coplanar      = res_out.coplanar;
	assign all_collinear = res_out.all_collinear;

endmodule

`default_nettype wire

// ===== sv/pscc_checker.sv =====
// pscc_props: port-level assertions for point_set_coplanarity_check and the
// bind that attaches them. Depends on the top level's port list.
`default_nettype none

module pscc_props #(
	parameter int COORD_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic [COORD_BITS-1:0] coord_x,
	input logic [COORD_BITS-1:0] coord_y,
	input logic [COORD_BITS-1:0] coord_z,
	input logic                  last_point,
	input logic                  empty,
	input logic                  pop,
	input logic                  coplanar,
	input logic                  all_collinear
);

	// no normal means no point ever left the plane
	a_collinear_is_coplanar: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && all_collinear |-> coplanar)
		else $error("all_collinear result without coplanar");

	// both queues come out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	// a waiting result beat is not dropped
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result beat lost while stalled");

	// a stalled result beat keeps its value
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(coplanar) && $stable(all_collinear))
		else $error("result beat changed while stalled");

endmodule

bind point_set_coplanarity_check pscc_props #(.COORD_BITS(COORD_BITS)) u_pscc_props (.*);

`default_nettype wire

// ===== sim/pscc_checker.sv =====
// pscc_checker: watches both queue sides of the coplanarity block, predicts the
// verdict of every point set and compares it with each result beat. Depends on pscc_pkg.
`default_nettype none

module pscc_checker import pscc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	input  logic [COORD_BITS-1:0] coord_z,
	input  logic                  last_point,
	input  logic                  empty,
	input  logic                  pop,
	input  logic                  coplanar,
	input  logic                  all_collinear,
	output int                    fail_count,
	output int                    pending,
	output int                    verdicts_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [63:0] wide_t;

	// Set state, exact in 64 bits.
	wide_t org_pt[3];
	wide_t base_dir[3];
	wide_t normal_v[3];
	wide_t offset_v;
	bit    have_origin;
	bit    have_dir;
	bit    have_normal;
	bit    in_plane;

	res_t  verdict_q[$];
	int    errors;
	int    checked_n;

	function automatic wide_t widen(input logic [COORD_BITS-1:0] raw);
		logic signed [COORD_BITS-1:0] s;
		wide_t w;
		s = raw;
		w = s;
		return w;
	endfunction

	task automatic clear_set();
		for (int i = 0; i < 3; i++) begin
			org_pt[i] = '0;
			base_dir[i] = '0;
			normal_v[i] = '0;
		end
		offset_v = '0;
		have_origin = 1'b0;
		have_dir = 1'b0;
		have_normal = 1'b0;
		in_plane = 1'b1;
	endtask

	task automatic fold_point(input logic [COORD_BITS-1:0] rx, ry, rz, input logic lst);
		wide_t p[3];
		wide_t d[3];
		wide_t c[3];
		res_t  v;
		p[0] = widen(rx);
		p[1] = widen(ry);
		p[2] = widen(rz);
		if (!have_origin) begin
			org_pt = p;
			have_origin = 1'b1;
		end else if (have_normal) begin
			if (p[0] * normal_v[0] + p[1] * normal_v[1] + p[2] * normal_v[2] != offset_v)
				in_plane = 1'b0;
		end else begin
			for (int i = 0; i < 3; i++)
				d[i] = p[i] - org_pt[i];
			if (!have_dir) begin
				// a copy of the origin gives no direction
				if (d[0] != 0 || d[1] != 0 || d[2] != 0) begin
					base_dir = d;
					have_dir = 1'b1;
				end
			end else begin
				c[0] = base_dir[1] * d[2] - base_dir[2] * d[1];
				c[1] = base_dir[2] * d[0] - base_dir[0] * d[2];
				c[2] = base_dir[0] * d[1] - base_dir[1] * d[0];
				if (c[0] != 0 || c[1] != 0 || c[2] != 0) begin
					normal_v = c;
					have_normal = 1'b1;
					offset_v = org_pt[0] * c[0] + org_pt[1] * c[1] + org_pt[2] * c[2];
				end
			end
		end
		if (lst) begin
			v.coplanar = in_plane;
			v.all_collinear = !have_normal;
			verdict_q.push_back(v);
			clear_set();
		end
	endtask

	task automatic note_mismatch(input string what, input string exp_s, input string act_s);
		if (errors < 50)
			$display("%0t ns: %s mismatch, expected %s, actual %s", $time, what, exp_s, act_s);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_set();
			verdict_q.delete();
			errors = 0;
			checked_n = 0;
		end else begin
			if (pop && !empty) begin
				if (verdict_q.size() == 0) begin
					note_mismatch("result beat", "none",
						$sformatf("coplanar=%0b all_collinear=%0b", coplanar, all_collinear));
				end else begin
					want = verdict_q.pop_front();
					if (coplanar !== want.coplanar)
						note_mismatch("coplanar", $sformatf("%0b", want.coplanar),
							$sformatf("%0b", coplanar));
					if (all_collinear !== want.all_collinear)
						note_mismatch("all_collinear", $sformatf("%0b", want.all_collinear),
							$sformatf("%0b", all_collinear));
					checked_n++;
				end
			end
			if (push && !full)
				fold_point(coord_x, coord_y, coord_z, last_point);
		end
		fail_count <= errors + ((arst_n && verdict_q.size() != 0) ? 0 : 0);
		pending <= verdict_q.size();
		verdicts_checked <= checked_n;
	end

endmodule

`default_nettype wire

// ===== sim/point_set_coplanarity_check_tb.sv =====
// point_set_coplanarity_check_tb: stimulus, back-pressure and verdict for the
// coplanarity block. Depends on pscc_pkg, pscc_checker and the block itself.
`default_nettype none

module point_set_coplanarity_check_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	// Longest quiet stretch is the receiver's long hold; keep a wide margin on top of it.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_POINTS = 700;
	localparam int HOLD_CYCLES = 150;

	logic          clk;
	logic          arst_n;
	logic          push;
	logic          full;
	logic [CW-1:0] coord_x;
	logic [CW-1:0] coord_y;
	logic [CW-1:0] coord_z;
	logic          last_point;
	logic          empty;
	logic          pop;
	logic          coplanar;
	logic          all_collinear;

	int fail_count;
	int pending;
	int verdicts_checked;

	int burst_left;
	int points_sent;
	int sets_sent;
	bit long_hold_req;

	point_set_coplanarity_check #(.COORD_BITS(CW)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.coord_z       (coord_z),
		.last_point    (last_point),
		.empty         (empty),
		.pop           (pop),
		.coplanar      (coplanar),
		.all_collinear (all_collinear)
	);

	pscc_checker #(.COORD_BITS(CW)) u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.coord_z          (coord_z),
		.last_point       (last_point),
		.empty            (empty),
		.pop              (pop),
		.coplanar         (coplanar),
		.all_collinear    (all_collinear),
		.fail_count       (fail_count),
		.pending          (pending),
		.verdicts_checked (verdicts_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Random coordinate over the whole signed range.
	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Random value in -lim..lim.
	function automatic int rand_small(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// One point beat. The sender runs in bursts; between bursts push drops
	// for a random gap, sometimes zero so that long unbroken runs happen.
	task automatic send_point(input int x, input int y, input int z, input bit lst);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
		push <= 1'b1;
		coord_x <= x[CW-1:0];
		coord_y <= y[CW-1:0];
		coord_z <= z[CW-1:0];
		last_point <= lst;
		do @(posedge clk); while (full);
		burst_left--;
		points_sent++;
	endtask

	// Stop offering points until every verdict owed has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One random point set. Most sets are built to stay in a plane (or on a
	// line) so the plane check is reached; some get one point knocked off by
	// one unit, the rest are plain noise and corner values.
	task automatic send_set();
		int kind, n, bad;
		int ox, oy, oz, ux, uy, uz, vx, vy, vz;
		int a, b, px, py, pz, axis, fixed;
		int corner[5];
		corner = '{-32768, -1, 0, 1, 32767};
		kind = $urandom_range(0, 9);
		n = $urandom_range(1, 8);
		bad = (n > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
		ox = rand_small(20000);
		oy = rand_small(20000);
		oz = rand_small(20000);
		ux = rand_small(100);
		uy = rand_small(100);
		uz = rand_small(100);
		vx = rand_small(100);
		vy = rand_small(100);
		vz = rand_small(100);
		axis = $urandom_range(0, 2);
		fixed = rand_coord();
		for (int i = 0; i < n; i++) begin
			case (kind)
				0, 1, 2, 3: begin
					// plane through the origin point, spanned by u and v
					if (i == 0 || $urandom_range(0, 9) == 0) begin
						a = 0;
						b = 0;
					end else begin
						a = rand_small(50);
						b = rand_small(50);
					end
					px = ox + a * ux + b * vx;
					py = oy + a * uy + b * vy;
					pz = oz + a * uz + b * vz;
					if (i == bad)
						pz = pz + (($urandom_range(0, 1) == 0) ? 1 : -1);
				end
				4: begin
					// points on one line, origin copies included
					a = (i == 0) ? 0 : rand_small(100);
					px = ox + a * ux;
					py = oy + a * uy;
					pz = oz + a * uz;
					if (i == bad)
						px = px + 1;
				end
				5: begin
					// axis-aligned plane with full-range coordinates
					px = rand_coord();
					py = rand_coord();
					pz = rand_coord();
					case (axis)
						0: px = (i == bad) ? (fixed ^ 1) : fixed;
						1: py = (i == bad) ? (fixed ^ 1) : fixed;
						default: pz = (i == bad) ? (fixed ^ 1) : fixed;
					endcase
				end
				7: begin
					// heavy on copies of the origin, the rest in a z plane
					if (i == 0 || $urandom_range(0, 1) == 0) begin
						px = ox;
						py = oy;
						pz = oz;
					end else begin
						px = ox + rand_small(3);
						py = oy + rand_small(3);
						pz = (i == bad) ? oz + 1 : oz;
					end
				end
				8: begin
					if (i > 2)
						break;
					px = rand_coord();
					py = rand_coord();
					pz = rand_coord();
				end
				9: begin
					px = corner[$urandom_range(0, 4)];
					py = corner[$urandom_range(0, 4)];
					pz = corner[$urandom_range(0, 4)];
				end
				default: begin
					px = rand_coord();
					py = rand_coord();
					pz = rand_coord();
				end
			endcase
			send_point(px, py, pz, (i == n - 1) || (kind == 8 && i == 2));
		end
		sets_sent++;
	endtask

	// Receiver: pops on a pattern of its own (steady, coin flip, sparse,
	// stalled), and once holds off for a long stretch on request.
	initial begin
		int mode, left;
		pop <= 1'b0;
		mode = 0;
		left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				pop <= 1'b0;
				for (int hold = 0; hold < HOLD_CYCLES; hold++)
					@(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(1, 30);
				end
				left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= 1'b0;
				endcase
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either side for too long.
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle = 0;
			else
				idle++;
		end
		$display("%0t ns: watchdog, no beat for %0d cycles, %0d verdicts owed",
			$time, WATCHDOG_LIMIT, pending);
		$display("Test completed with failures");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		coord_x <= '0;
		coord_y <= '0;
		coord_z <= '0;
		last_point <= 1'b0;
		burst_left = 0;
		points_sent = 0;
		sets_sent = 0;
		long_hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-point sets at zero and at the extremes
		send_point(0, 0, 0, 1'b1);
		send_point(-32768, 32767, -32768, 1'b1);
		// copies of the origin before the direction, before and after the normal
		send_point(5, -7, 9, 1'b0);
		send_point(5, -7, 9, 1'b0);
		send_point(6, -7, 9, 1'b0);
		send_point(5, -7, 9, 1'b0);
		send_point(5, -6, 9, 1'b0);
		send_point(5, -7, 9, 1'b1);
		// corner points that do not lie in one plane
		send_point(-32768, -32768, -32768, 1'b0);
		send_point(32767, -32768, -32768, 1'b0);
		send_point(-32768, 32767, -32768, 1'b0);
		send_point(32767, 32767, 32767, 1'b1);
		// all on one line
		send_point(1, 2, 3, 1'b0);
		send_point(2, 4, 6, 1'b0);
		send_point(3, 6, 9, 1'b0);
		send_point(-1, -2, -3, 1'b1);
		// plane z = max with corner x, y
		send_point(-32768, -32768, 32767, 1'b0);
		send_point(32767, -32768, 32767, 1'b0);
		send_point(-32768, 32767, 32767, 1'b0);
		send_point(32767, 32767, 32767, 1'b0);
		send_point(0, 0, 32767, 1'b1);
		// two-point set across the whole range
		send_point(32767, 32767, 32767, 1'b0);
		send_point(-32768, -32768, -32768, 1'b1);
		wait_drained();

		while (points_sent < RANDOM_POINTS / 2)
			send_set();

		// Long receiver hold while single-point sets keep coming: results
		// back up until the block stops taking points.
		long_hold_req = 1'b1;
		repeat (24)
			send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
		sets_sent += 24;

		while (points_sent < (3 * RANDOM_POINTS) / 4)
			send_set();
		wait_drained();
		while (points_sent < RANDOM_POINTS + 23)
			send_set();

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Summary: %0d points in %0d sets, %0d verdicts checked, %0d mismatches",
			points_sent, sets_sent, verdicts_checked, fail_count);
		$display("Covered: origin copies, lines, planes, off-plane points, corners, full stall");
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/pscc_pkg.sv
sv/pscc_fifo.sv
sv/pscc_back.sv
sv/point_set_coplanarity_check.sv
sv/pscc_checker.sv
sim/pscc_checker.sv
sim/point_set_coplanarity_check_tb.sv
